// File: design/mslw_pkg.sv
// Shared types and constants of the mean-square line window monitor.
package mslw_pkg;

  // Field and datapath widths
  localparam int SUM_W = 32;
  localparam int LEN_W = 13;
  localparam int MS_W  = 20;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  // Saturation value of the mean square
  localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SAMPLES = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_TRIP       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_RECOVER    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_RECOVER   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_TRIP      = 3'd4;

  // Register reset values
  localparam logic [LEN_W-1:0] WINDOW_SAMPLES_RST = 13'd17;
  localparam logic [MS_W-1:0]  LOW_TRIP_RST       = 20'd50971;
  localparam logic [MS_W-1:0]  LOW_RECOVER_RST    = 20'd57700;
  localparam logic [MS_W-1:0]  HIGH_RECOVER_RST   = 20'd137020;
  localparam logic [MS_W-1:0]  HIGH_TRIP_RST      = 20'd159233;

  // Line window states, as reported on line_state
  typedef enum logic [1:0] {
    LINE_STARTUP = 2'd0,
    LINE_LOW     = 2'd1,
    LINE_VALID   = 2'd2,
    LINE_HIGH    = 2'd3
  } line_state_t;

  // One finished window waiting for the divider
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [LEN_W-1:0] len;
  } win_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Hysteresis thresholds
  typedef struct packed {
    logic [MS_W-1:0] low_trip;
    logic [MS_W-1:0] low_recover;
    logic [MS_W-1:0] high_recover;
    logic [MS_W-1:0] high_trip;
  } thresholds_t;

endpackage

// File: design/mslw_front.sv
// Front end: squares samples, accumulates them and closes windows.
module mslw_front #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [SAMPLE_BITS-1:0]      sample,
  input  logic [mslw_pkg::LEN_W-1:0]  window_samples,
  input  mslw_pkg::q_status_t         q_stat,
  output logic                        push,
  output mslw_pkg::win_entry_t        push_entry
);

  logic [mslw_pkg::SUM_W-1:0]   sum;
  logic [mslw_pkg::LEN_W-1:0]   count;
  logic [2*SAMPLE_BITS-1:0]     square;
  logic [mslw_pkg::SUM_W-1:0]   sum_next;
  logic [mslw_pkg::LEN_W-1:0]   count_next;
  logic [mslw_pkg::LEN_W-1:0]   len;
  logic                         accept;
  logic                         win_end;

  // A sample is taken only while the queue has room for a closing window
  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // Zero length behaves as one
  assign len = (window_samples == '0) ? mslw_pkg::LEN_W'(1) : window_samples;

  // Square and accumulate, sum wraps modulo 2^32
  assign square     = sample * sample;
  assign sum_next   = sum + mslw_pkg::SUM_W'(square);
  assign count_next = count + mslw_pkg::LEN_W'(1);
  assign win_end    = (count_next >= len) || (count_next == '0);

  assign push            = accept && win_end;
  assign push_entry.sum  = sum_next;
  assign push_entry.len  = len;

  // Running sum and sample count
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (accept) begin
      if (win_end) begin
        sum   <= '0;
        count <= '0;
      end else begin
        sum   <= sum_next;
        count <= count_next;
      end
    end
  end

endmodule

// File: design/mslw_queue.sv
// Two-entry queue of closed windows between front and back.
module mslw_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mslw_pkg::win_entry_t  push_entry,
  input  logic                  pop,
  output mslw_pkg::win_entry_t  head,
  output mslw_pkg::q_status_t   q_stat
);

  localparam int PTR_W = $clog2(mslw_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(mslw_pkg::Q_DEPTH + 1);

  mslw_pkg::win_entry_t   entries [mslw_pkg::Q_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       cnt;

  assign q_stat.full  = (cnt == CNT_W'(mslw_pkg::Q_DEPTH));
  assign q_stat.empty = (cnt == '0);
  assign head         = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + CNT_W'(1);
      end else if (pop && !push) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  // Front must never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("queue pushed while full");

  // Back must never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");
`endif

endmodule

// File: design/mslw_back.sv
// Back end: restoring divider, saturation, hysteresis machine and result register.
module mslw_back (
  input  logic                        clk,
  input  logic                        rst,
  input  mslw_pkg::win_entry_t        head,
  input  mslw_pkg::q_status_t         q_stat,
  output logic                        pop,
  input  mslw_pkg::thresholds_t       thr,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mslw_pkg::MS_W-1:0]   mean_square,
  output logic                        line_good,
  output logic [1:0]                  line_state
);

  localparam int STEP_W = $clog2(mslw_pkg::MS_W);

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

  back_state_t                  st;
  mslw_pkg::line_state_t        wstate;
  mslw_pkg::line_state_t        wstate_next;
  logic [mslw_pkg::LEN_W-1:0]   len;
  logic [mslw_pkg::LEN_W-1:0]   rem;
  logic [mslw_pkg::LEN_W-1:0]   rem_next;
  logic [mslw_pkg::MS_W-1:0]    quot;
  logic [STEP_W-1:0]            step;
  logic [mslw_pkg::LEN_W:0]     trial;
  logic                         qbit;
  logic                         sat;
  logic                         load_out;

  assign pop = (st == B_IDLE) && !q_stat.empty;

  // Quotient above 20 bits when sum >= len * 2^20
  assign sat = {1'b0, head.sum} >= {head.len, {mslw_pkg::MS_W{1'b0}}};

  // One restoring step: bring down the next dividend bit
  assign trial    = {rem, quot[mslw_pkg::MS_W-1]};
  assign qbit     = trial >= {1'b0, len};
  assign rem_next = qbit ? mslw_pkg::LEN_W'(trial - {1'b0, len})
                         : trial[mslw_pkg::LEN_W-1:0];

  // Hysteresis transitions on the finished mean square
  always_comb begin
    unique case (wstate)
      mslw_pkg::LINE_LOW: begin
        wstate_next = (quot >= thr.low_recover) ? mslw_pkg::LINE_VALID
                                                : mslw_pkg::LINE_LOW;
      end
      mslw_pkg::LINE_VALID: begin
        if (quot <= thr.low_trip) begin
          wstate_next = mslw_pkg::LINE_LOW;
        end else if (quot >= thr.high_trip) begin
          wstate_next = mslw_pkg::LINE_HIGH;
        end else begin
          wstate_next = mslw_pkg::LINE_VALID;
        end
      end
      mslw_pkg::LINE_HIGH: begin
        wstate_next = (quot <= thr.high_recover) ? mslw_pkg::LINE_VALID
                                                 : mslw_pkg::LINE_HIGH;
      end
      default: begin
        wstate_next = mslw_pkg::LINE_LOW;
      end
    endcase
  end

  assign load_out = (st == B_DONE) && (!out_valid || out_ready);

  // Sequencer, divider registers, window state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_IDLE;
      wstate    <= mslw_pkg::LINE_STARTUP;
      out_valid <= 1'b0;
    end else begin
      // A new result replaces one taken in the same cycle
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        B_IDLE: begin
          if (!q_stat.empty) begin
            len <= head.len;
            if (sat) begin
              quot <= mslw_pkg::MS_MAX;
              st   <= B_DONE;
            end else begin
              rem  <= mslw_pkg::LEN_W'(head.sum[mslw_pkg::SUM_W-1:mslw_pkg::MS_W]);
              quot <= head.sum[mslw_pkg::MS_W-1:0];
              step <= STEP_W'(mslw_pkg::MS_W - 1);
              st   <= B_DIV;
            end
          end
        end
        B_DIV: begin
          rem  <= rem_next;
          quot <= {quot[mslw_pkg::MS_W-2:0], qbit};
          if (step == '0) begin
            st <= B_DONE;
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        B_DONE: begin
          if (load_out) begin
            mean_square <= quot;
            line_good   <= (wstate == mslw_pkg::LINE_VALID);
            line_state  <= wstate_next;
            wstate      <= wstate_next;
            st          <= B_IDLE;
          end
        end
        default: begin
          st <= B_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // Partial remainder stays below the divisor during division
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (st == B_DIV) |-> (rem < len))
    else $error("partial remainder not below divisor");

  // A result taken from the valid state always leaves startup behind
  a_valid_not_startup: assert property (@(posedge clk) disable iff (rst)
    (out_valid && line_good) |-> (line_state != mslw_pkg::LINE_STARTUP))
    else $error("line_good reported with startup state");

  // Once left, startup is never re-entered
  a_no_return_startup: assert property (@(posedge clk) disable iff (rst)
    (wstate != mslw_pkg::LINE_STARTUP) |=> (wstate != mslw_pkg::LINE_STARTUP))
    else $error("window machine returned to startup");
`endif

endmodule

// File: design/mean_square_line_window_monitor_unit.sv
// Top level of the mean-square line window monitor.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------
//   in       | in_valid / in_ready | sample
//   out      | out_valid/out_ready | mean_square, line_good, line_state
//   cfg      | cfg_we              | cfg_index, cfg_data
//
// A sample is taken every cycle while the window queue has room.
// Each closed window passes through the back end in order: B_IDLE loads it and
// checks saturation, B_DIV runs the one-bit restoring divider, and B_DONE updates
// the window machine and loads the result register; a saturated quotient skips
// the divider. B_DONE waits while a held result is not yet taken by out_ready.
// Two closed windows can wait in the queue; until it is full, the front keeps
// taking samples as a result waits. Synchronous reset clears all control state.
module mean_square_line_window_monitor_unit #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [SAMPLE_BITS-1:0]            sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mslw_pkg::MS_W-1:0]         mean_square,
  output logic                              line_good,
  output logic [1:0]                        line_state,
  input  logic                              cfg_we,
  input  logic [mslw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mslw_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [mslw_pkg::LEN_W-1:0]  window_samples;
  mslw_pkg::thresholds_t       thr;
  mslw_pkg::q_status_t         q_stat;
  mslw_pkg::win_entry_t        push_entry;
  mslw_pkg::win_entry_t        head;
  logic                        push;
  logic                        pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_samples   <= mslw_pkg::WINDOW_SAMPLES_RST;
      thr.low_trip     <= mslw_pkg::LOW_TRIP_RST;
      thr.low_recover  <= mslw_pkg::LOW_RECOVER_RST;
      thr.high_recover <= mslw_pkg::HIGH_RECOVER_RST;
      thr.high_trip    <= mslw_pkg::HIGH_TRIP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mslw_pkg::CFG_WINDOW_SAMPLES: window_samples   <= cfg_data[mslw_pkg::LEN_W-1:0];
        mslw_pkg::CFG_LOW_TRIP:       thr.low_trip     <= cfg_data;
        mslw_pkg::CFG_LOW_RECOVER:    thr.low_recover  <= cfg_data;
        mslw_pkg::CFG_HIGH_RECOVER:   thr.high_recover <= cfg_data;
        mslw_pkg::CFG_HIGH_TRIP:      thr.high_trip    <= cfg_data;
        default: ;
      endcase
    end
  end

  mslw_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .window_samples (window_samples),
    .q_stat         (q_stat),
    .push           (push),
    .push_entry     (push_entry)
  );

  mslw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  mslw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .thr         (thr),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mean_square (mean_square),
    .line_good   (line_good),
    .line_state  (line_state)
  );

endmodule
